// File: hdl/cac_pkg.sv
// ----------------------------------------------------------------------------
// cac_pkg
// Shared widths, codes and controller/datapath signal groups of the
// circular autocorrelation engine.
// ----------------------------------------------------------------------------
package cac_pkg;

  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned ADDR_W    = 10;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned MAX_LAGS  = 64;
  localparam int unsigned RUN_W     = 7;
  localparam int unsigned LAG_W     = 10;
  localparam int unsigned END_W     = 11;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SUM_W     = 27;
  localparam int unsigned SQ_W      = 41;
  localparam int unsigned CROSS_W   = 42;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned DIV_W     = 68;
  localparam int unsigned DIV_CNT_W = 7;
  localparam int unsigned DEN_W     = 54;
  localparam int unsigned D2_W      = 30;
  localparam int unsigned ROOT_W    = 64;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned ROOT_CNT_W = 6;

  typedef logic [1:0] action_t;
  localparam action_t ACT_PUSH  = 2'd0;
  localparam action_t ACT_POP   = 2'd1;
  localparam action_t ACT_QUERY = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_SINGLE = 2'd2;
  localparam status_t ST_ZVAR   = 2'd3;

  typedef logic [2:0] div_sel_t;
  localparam div_sel_t DIV_MOD = 3'd0;
  localparam div_sel_t DIV_AVG = 3'd1;
  localparam div_sel_t DIV_SQA = 3'd2;
  localparam div_sel_t DIV_VAR = 3'd3;
  localparam div_sel_t DIV_RAT = 3'd4;

  typedef struct packed {
    logic     push;
    logic     pop;
    logic     lag_load;
    logic     lag_inc;
    logic     div_start;
    div_sel_t div_sel;
    logic     walk_start;
    logic     mul;
    logic     den;
    logic     sqrt_start;
    logic     ac_sat;
    logic     out_load;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic div_idle;
    logic walk_busy;
    logic sqrt_busy;
    logic den_pos;
    logic ratio_sat;
    logic out_busy;
  } stat_t;

endpackage

// File: hdl/cac_in_if.sv
// ----------------------------------------------------------------------------
// cac_in_if
// Command channel: push, pop or lag range query.
// ----------------------------------------------------------------------------
interface cac_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic signed [15:0]  sample;
  logic [9:0]          lag_first;
  logic [10:0]         lag_end;

  modport source (output valid, action, sample, lag_first, lag_end, input ready);
  modport sink   (input valid, action, sample, lag_first, lag_end, output ready);
endinterface

// File: hdl/cac_out_if.sv
// ----------------------------------------------------------------------------
// cac_out_if
// Result channel: one beat per lag.
// ----------------------------------------------------------------------------
interface cac_out_if;
  logic                valid;
  logic                ready;
  logic [9:0]          lag;
  logic signed [15:0]  autocorrelation;
  logic signed [25:0]  total;
  logic signed [15:0]  average;
  logic [15:0]         square_average;
  logic [15:0]         standard_error;
  logic [1:0]          status;
  logic                last;

  modport source (output valid, lag, autocorrelation, total, average, square_average,
                  standard_error, status, last, input ready);
  modport sink   (input valid, lag, autocorrelation, total, average, square_average,
                  standard_error, status, last, output ready);
endinterface

// File: hdl/cac_div.sv
// ----------------------------------------------------------------------------
// cac_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module cac_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cac_pkg::DIV_W-1:0]    dividend_i,
  input  logic [cac_pkg::DIV_W-1:0]    divisor_i,
  output logic                         busy_o,
  output logic [cac_pkg::DIV_W-1:0]    quot_o,
  output logic [cac_pkg::DIV_W-1:0]    rem_o
);

  logic [cac_pkg::DIV_W-1:0]     rem_q, quo_q, dsr_q;
  logic [cac_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [cac_pkg::DIV_W:0]       trial, diff;
  logic                          fits;

  assign trial = {rem_q, quo_q[cac_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= cac_pkg::DIV_CNT_W'(cac_pkg::DIV_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[cac_pkg::DIV_W-1:0] : trial[cac_pkg::DIV_W-1:0];
      quo_q <= {quo_q[cac_pkg::DIV_W-2:0], fits};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: hdl/cac_dp.sv
// ----------------------------------------------------------------------------
// cac_dp
// Datapath: sample store, lag walk with multiply-accumulate, statistics
// arithmetic, shared divider, square root unit and result register.
// ----------------------------------------------------------------------------
module cac_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cac_pkg::cmd_t         cmd_i,
  output cac_pkg::stat_t        stat_o,
  input  logic signed [15:0]    sample_i,
  input  logic [9:0]            lag_first_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [9:0]            out_lag_o,
  output logic signed [15:0]    out_ac_o,
  output logic signed [25:0]    out_total_o,
  output logic signed [15:0]    out_avg_o,
  output logic [15:0]           out_sqa_o,
  output logic [15:0]           out_se_o,
  output logic [1:0]            out_status_o,
  output logic                  out_last_o
);

  // store and count
  logic [cac_pkg::SAMPLE_W-1:0] mem [cac_pkg::DEPTH];
  logic [cac_pkg::CNT_W-1:0]    count_q;
  logic [cac_pkg::LAG_W-1:0]    lag_q;
  logic [cac_pkg::ADDR_W-1:0]   sh_q;

  // walk pipeline
  logic [cac_pkg::CNT_W-1:0]    rd_i_q;
  logic [cac_pkg::ADDR_W-1:0]   rd_j_q;
  logic                         issue_q, v1_q, v2_q;
  logic signed [15:0]           a_q, b_q, pa_q;
  logic signed [cac_pkg::PROD_W-1:0] pab_q, paa_q;
  logic signed [cac_pkg::SUM_W-1:0]   sum_q;
  logic [cac_pkg::SQ_W-1:0]           sq_q;
  logic signed [cac_pkg::CROSS_W-1:0] cross_q;

  // products and differences
  logic [51:0]                  nq_q;
  logic [50:0]                  ss_q;
  logic signed [52:0]           nc_q;
  logic [21:0]                  nn_q;
  logic [cac_pkg::D2_W-1:0]     d2_q;
  logic signed [cac_pkg::DEN_W-1:0] den_q;
  logic [cac_pkg::DEN_W-1:0]    mag_q;
  logic                         neg_q;

  // results
  logic signed [15:0]           avg_q, ac_q;
  logic [15:0]                  sqa_q, se_q;
  logic [cac_pkg::ROOT_W-1:0]   v_q;

  // square root
  logic [cac_pkg::ROOT_W-1:0]   sv_q, root_q, bit_q, root_t, root_d;
  logic [cac_pkg::ROOT_CNT_W-1:0] sqcnt_q;
  logic                         root_fits;

  // divider
  logic                         div_pend_q, div_busy;
  cac_pkg::div_sel_t            div_sel_q;
  logic [cac_pkg::DIV_W-1:0]    div_num, div_den, div_quot, div_rem;

  // output register
  logic                         out_valid_q, out_last_q;
  logic [9:0]                   out_lag_q;
  logic signed [15:0]           out_ac_q, out_avg_q;
  logic signed [25:0]           out_total_q;
  logic [15:0]                  out_sqa_q, out_se_q;
  cac_pkg::status_t             out_status_q, status;

  logic signed [53:0]           ss_full;
  logic signed [52:0]           nc_d;
  logic [31:0]                  d2_full;
  logic signed [cac_pkg::DEN_W-1:0] den_d, num_d;
  logic [cac_pkg::SUM_W-1:0]    sabs;
  logic [16:0]                  rq;
  logic                         den_pos;

  // -------------------------------------------------------------- store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.push && count_q < cac_pkg::CNT_W'(cac_pkg::DEPTH)) begin
      count_q <= count_q + 1'b1;
    end else if (cmd_i.pop && count_q != '0) begin
      count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && count_q < cac_pkg::CNT_W'(cac_pkg::DEPTH)) begin
      mem[count_q[cac_pkg::ADDR_W-1:0]] <= sample_i;
    end
    if (issue_q) begin
      a_q <= mem[rd_i_q[cac_pkg::ADDR_W-1:0]];
      b_q <= mem[rd_j_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q <= '0;
    end else if (cmd_i.lag_load) begin
      lag_q <= lag_first_i;
    end else if (cmd_i.lag_inc) begin
      lag_q <= lag_q + 1'b1;
    end
  end

  // -------------------------------------------------------------- walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      sum_q   <= '0;
      sq_q    <= '0;
      cross_q <= '0;
    end else begin
      v1_q <= issue_q;
      v2_q <= v1_q;
      if (cmd_i.walk_start) begin
        issue_q <= 1'b1;
        sum_q   <= '0;
        sq_q    <= '0;
        cross_q <= '0;
      end else begin
        if (issue_q && rd_i_q == count_q - 1'b1) begin
          issue_q <= 1'b0;
        end
        if (v2_q) begin
          sum_q   <= sum_q + cac_pkg::SUM_W'(pa_q);
          sq_q    <= sq_q + cac_pkg::SQ_W'(unsigned'(paa_q));
          cross_q <= cross_q + cac_pkg::CROSS_W'(pab_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      rd_i_q <= '0;
      rd_j_q <= sh_q;
    end else if (issue_q) begin
      rd_i_q <= rd_i_q + 1'b1;
      // wrap the partner index at the count
      if ({1'b0, rd_j_q} + 1'b1 == count_q) begin
        rd_j_q <= '0;
      end else begin
        rd_j_q <= rd_j_q + 1'b1;
      end
    end
    if (v1_q) begin
      pab_q <= a_q * b_q;
      paa_q <= a_q * a_q;
      pa_q  <= a_q;
    end
  end

  // -------------------------------------------------------------- products
  assign ss_full = 54'(sum_q) * 54'(sum_q);
  assign nc_d    = 53'($signed({1'b0, count_q})) * 53'(cross_q);
  assign d2_full = 32'(nn_q) * 32'(count_q - 1'b1);
  assign den_d   = $signed({2'b0, nq_q}) - $signed({3'b0, ss_q});
  assign num_d   = cac_pkg::DEN_W'(nc_q) - $signed({3'b0, ss_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      nq_q <= 52'(count_q) * 52'(sq_q);
      ss_q <= ss_full[50:0];
      nc_q <= nc_d;
      nn_q <= 22'(count_q) * 22'(count_q);
    end
    if (cmd_i.den) begin
      d2_q  <= d2_full[cac_pkg::D2_W-1:0];
      den_q <= den_d;
      neg_q <= num_d[cac_pkg::DEN_W-1];
      mag_q <= num_d[cac_pkg::DEN_W-1] ? unsigned'(-num_d) : unsigned'(num_d);
    end
  end

  assign den_pos = !den_q[cac_pkg::DEN_W-1] && den_q != '0;

  // -------------------------------------------------------------- divider
  assign sabs = sum_q[cac_pkg::SUM_W-1] ? unsigned'(-sum_q) : unsigned'(sum_q);

  always_comb begin
    div_num = '0;
    div_den = '0;
    unique case (cmd_i.div_sel)
      cac_pkg::DIV_MOD: begin
        div_num = cac_pkg::DIV_W'(lag_q);
        div_den = cac_pkg::DIV_W'(count_q);
      end
      cac_pkg::DIV_AVG: begin
        div_num = cac_pkg::DIV_W'(sabs);
        div_den = cac_pkg::DIV_W'(count_q);
      end
      cac_pkg::DIV_SQA: begin
        div_num = cac_pkg::DIV_W'(sq_q[cac_pkg::SQ_W-1:15]);
        div_den = cac_pkg::DIV_W'(count_q);
      end
      cac_pkg::DIV_VAR: begin
        div_num = cac_pkg::DIV_W'(den_q[cac_pkg::DEN_W-2:0]);
        div_den = cac_pkg::DIV_W'(d2_q);
      end
      cac_pkg::DIV_RAT: begin
        div_num = {mag_q[52:0], 15'b0};
        div_den = cac_pkg::DIV_W'(den_q[cac_pkg::DEN_W-2:0]);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  cac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign rq = div_quot[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_pend_q <= 1'b0;
    end else if (cmd_i.div_start) begin
      div_pend_q <= 1'b1;
    end else if (!div_busy) begin
      div_pend_q <= 1'b0;
    end
  end

  // square root step
  assign root_t    = root_q + bit_q;
  assign root_fits = sv_q >= root_t;
  assign root_d    = root_fits ? (root_q >> 1) + bit_q : root_q >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqcnt_q <= '0;
    end else if (cmd_i.sqrt_start) begin
      sqcnt_q <= cac_pkg::ROOT_CNT_W'(cac_pkg::ROOT_STEPS);
    end else if (sqcnt_q != '0) begin
      sqcnt_q <= sqcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sv_q   <= v_q;
      root_q <= '0;
      bit_q  <= {2'b01, {(cac_pkg::ROOT_W-2){1'b0}}};
    end else if (sqcnt_q != '0) begin
      if (root_fits) begin
        sv_q <= sv_q - root_t;
      end
      root_q <= root_d;
      bit_q  <= bit_q >> 2;
    end

    if (cmd_i.walk_start) begin
      se_q <= '0;
      ac_q <= '0;
    end else begin
      if (sqcnt_q == cac_pkg::ROOT_CNT_W'(1)) begin
        se_q <= (root_d > cac_pkg::ROOT_W'(32768)) ? 16'h8000 : root_d[15:0];
      end
      if (cmd_i.ac_sat) begin
        ac_q <= neg_q ? 16'sh8000 : 16'sh7fff;
      end else if (div_pend_q && !div_busy && div_sel_q == cac_pkg::DIV_RAT) begin
        if (neg_q) begin
          ac_q <= (rq >= 17'd32768) ? 16'sh8000 : -$signed(rq[15:0]);
        end else begin
          ac_q <= (rq > 17'd32767) ? 16'sh7fff : $signed(rq[15:0]);
        end
      end
    end

    if (cmd_i.div_start) begin
      div_sel_q <= cmd_i.div_sel;
    end
    if (div_pend_q && !div_busy) begin
      case (div_sel_q)
        cac_pkg::DIV_MOD: sh_q  <= div_rem[cac_pkg::ADDR_W-1:0];
        cac_pkg::DIV_AVG: avg_q <= sum_q[cac_pkg::SUM_W-1] ? -$signed(div_quot[15:0])
                                                          : $signed(div_quot[15:0]);
        cac_pkg::DIV_SQA: sqa_q <= div_quot[15:0];
        cac_pkg::DIV_VAR: v_q   <= div_quot[cac_pkg::ROOT_W-1:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------- result
  always_comb begin
    if (count_q == '0) begin
      status = cac_pkg::ST_EMPTY;
    end else if (count_q == cac_pkg::CNT_W'(1)) begin
      status = cac_pkg::ST_SINGLE;
    end else if (!den_pos) begin
      status = cac_pkg::ST_ZVAR;
    end else begin
      status = cac_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_lag_q    <= lag_q;
      out_status_q <= status;
      out_last_q   <= cmd_i.out_last;
      out_ac_q     <= (status == cac_pkg::ST_OK) ? ac_q : '0;
      out_se_q     <= (status == cac_pkg::ST_OK) ? se_q : '0;
      out_total_q  <= (status == cac_pkg::ST_EMPTY) ? '0 : sum_q[25:0];
      out_avg_q    <= (status == cac_pkg::ST_EMPTY) ? '0 : avg_q;
      out_sqa_q    <= (status == cac_pkg::ST_EMPTY) ? '0 : sqa_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_lag_o    = out_lag_q;
  assign out_ac_o     = out_ac_q;
  assign out_total_o  = out_total_q;
  assign out_avg_o    = out_avg_q;
  assign out_sqa_o    = out_sqa_q;
  assign out_se_o     = out_se_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

  assign stat_o.cnt_zero  = count_q == '0;
  assign stat_o.cnt_one   = count_q == cac_pkg::CNT_W'(1);
  assign stat_o.div_idle  = !div_busy && !div_pend_q;
  assign stat_o.walk_busy = issue_q || v1_q || v2_q;
  assign stat_o.sqrt_busy = sqcnt_q != '0;
  assign stat_o.den_pos   = den_pos;
  assign stat_o.ratio_sat = {1'b0, mag_q} >= {den_q, 1'b0};
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

// File: hdl/cac_ctrl.sv
// ----------------------------------------------------------------------------
// cac_ctrl
// Sequencer: takes commands, steps each lag of a query through walk,
// products, divisions and square root, and hands results to the output.
// ----------------------------------------------------------------------------
module cac_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [9:0]          lag_first_i,
  input  logic [10:0]         lag_end_i,
  input  cac_pkg::stat_t      stat_i,
  output cac_pkg::cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LAG   = 4'd1;
  localparam logic [3:0] S_MODW  = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_DEN   = 4'd4;
  localparam logic [3:0] S_AVGW  = 4'd5;
  localparam logic [3:0] S_SQAW  = 4'd6;
  localparam logic [3:0] S_VARW  = 4'd7;
  localparam logic [3:0] S_SQRTW = 4'd8;
  localparam logic [3:0] S_RATW  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]                state_q, state_d;
  logic [cac_pkg::RUN_W-1:0] left_q, left_d;
  logic [10:0]               span;
  logic                      accept, is_last;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = state_q == S_IDLE;
  assign span       = lag_end_i - {1'b0, lag_first_i};
  assign is_last    = left_q == cac_pkg::RUN_W'(1);

  always_comb begin
    state_d = state_q;
    left_d  = left_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.push = action_i == cac_pkg::ACT_PUSH;
          cmd_o.pop  = action_i == cac_pkg::ACT_POP;
          if (action_i == cac_pkg::ACT_QUERY && {1'b0, lag_first_i} < lag_end_i) begin
            cmd_o.lag_load = 1'b1;
            left_d  = (span > 11'(cac_pkg::MAX_LAGS)) ? cac_pkg::RUN_W'(cac_pkg::MAX_LAGS)
                                                     : span[cac_pkg::RUN_W-1:0];
            state_d = S_LAG;
          end
        end
      end
      S_LAG: begin
        if (stat_i.cnt_zero) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = cac_pkg::DIV_MOD;
          state_d         = S_MODW;
        end
      end
      S_MODW: begin
        if (stat_i.div_idle) begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_WALK;
        end
      end
      S_WALK: begin
        if (!stat_i.walk_busy) begin
          cmd_o.mul = 1'b1;
          state_d   = S_DEN;
        end
      end
      S_DEN: begin
        cmd_o.den       = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = cac_pkg::DIV_AVG;
        state_d         = S_AVGW;
      end
      S_AVGW: begin
        if (stat_i.div_idle) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = cac_pkg::DIV_SQA;
          state_d         = S_SQAW;
        end
      end
      S_SQAW: begin
        if (stat_i.div_idle) begin
          if (stat_i.cnt_one || !stat_i.den_pos) begin
            state_d = S_EMIT;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = cac_pkg::DIV_VAR;
            state_d         = S_VARW;
          end
        end
      end
      S_VARW: begin
        if (stat_i.div_idle) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = S_SQRTW;
        end
      end
      S_SQRTW: begin
        if (!stat_i.sqrt_busy) begin
          if (stat_i.ratio_sat) begin
            cmd_o.ac_sat = 1'b1;
            state_d      = S_EMIT;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = cac_pkg::DIV_RAT;
            state_d         = S_RATW;
          end
        end
      end
      S_RATW: begin
        if (stat_i.div_idle) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the result register is free
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = is_last;
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.lag_inc = 1'b1;
            left_d        = left_q - 1'b1;
            state_d       = S_LAG;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      left_q  <= left_d;
    end
  end

endmodule

// File: hdl/circular_autocorrelation_engine.sv
// ----------------------------------------------------------------------------
// circular_autocorrelation_engine
// Sample store with push/pop and per-lag normalised circular autocorrelation.
// ----------------------------------------------------------------------------
// A query gives one result beat per lag, at most 64. Each lag walks the n
// stored samples through the two read ports of the store with one
// multiply-accumulate per cycle, then uses up to five runs of the one
// shared bit-serial divider and a 32-step square root. With no samples a
// lag goes straight to its result beat. The sample store has no reset; only
// entries below the count are ever read. A new command is taken as soon as
// the last beat of a query sits in the result register.
// ----------------------------------------------------------------------------
module circular_autocorrelation_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  cac_in_if.sink    in_i,
  cac_out_if.source out_o
);

  cac_pkg::cmd_t  cmd;
  cac_pkg::stat_t stat;

  cac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .action_i    (in_i.action),
    .lag_first_i (in_i.lag_first),
    .lag_end_i   (in_i.lag_end),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cac_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .sample_i     (in_i.sample),
    .lag_first_i  (in_i.lag_first),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_lag_o    (out_o.lag),
    .out_ac_o     (out_o.autocorrelation),
    .out_total_o  (out_o.total),
    .out_avg_o    (out_o.average),
    .out_sqa_o    (out_o.square_average),
    .out_se_o     (out_o.standard_error),
    .out_status_o (out_o.status),
    .out_last_o   (out_o.last)
  );

endmodule

// File: hdl/cac_checker.sv
// ----------------------------------------------------------------------------
// cac_checker
// Port-level checks of the autocorrelation engine, bound to the top level.
// ----------------------------------------------------------------------------
module cac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_action_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_last_i,
  input logic [9:0]  out_lag_i,
  input logic [1:0]  out_status_i
);

  // a stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_lag_i)
                                    && $stable(out_status_i) && $stable(out_last_i))
    else $error("result beat changed while stalled");

  // a fresh result is only produced while commands are held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while command port was open");

  // push and pop produce no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i != cac_pkg::ACT_QUERY |=> !$rose(out_valid_i))
    else $error("result after push or pop");

  // the last beat of a query reopens the command port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) && out_last_i |-> in_ready_i)
    else $error("command port closed after final beat");

endmodule

bind circular_autocorrelation_engine cac_checker u_cac_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_action_i  (in_i.action),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_last_i   (out_o.last),
  .out_lag_i    (out_o.lag),
  .out_status_i (out_o.status)
);
